FILE: src/tsq_pkg.sv
package tsq_pkg;

    // group and sample geometry
    localparam int GROUP_SIZE  = 5;
    localparam int TRIM_COUNT  = 1;
    localparam int SAMPLE_BITS = 12;

    localparam int SMP_IN_W    = 12;
    localparam int COORD_W     = 16;
    localparam int RANGE_W     = 12;
    localparam int GAIN_FRAC   = 14;
    localparam int SLOT_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    // trimmed mean: when trimming would drop everything the middle element is taken
    localparam bit TRIM_ALL    = (2 * TRIM_COUNT >= GROUP_SIZE);
    localparam int KEEP        = TRIM_ALL ? 1 : GROUP_SIZE - 2 * TRIM_COUNT;
    localparam int KEEP_LOG    = $clog2(KEEP);
    localparam int SUM_W       = SAMPLE_BITS + KEEP_LOG;
    localparam int DIV_SHIFT   = SUM_W + KEEP_LOG;
    localparam int RECIP_W     = SUM_W + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << DIV_SHIFT) + KEEP - 1) / KEEP;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int DIV_PROD_W  = SUM_W + RECIP_W;

    localparam int CMP_W       = (SAMPLE_BITS > RANGE_W) ? SAMPLE_BITS : RANGE_W;

    // coordinate mapping widths
    localparam int PROD_W      = COORD_W + SAMPLE_BITS + 1;
    localparam int MAP_W       = ((PROD_W > COORD_W + GAIN_FRAC) ? PROD_W
                                                                 : COORD_W + GAIN_FRAC) + 1;

    localparam logic [COORD_W-1:0] NO_TOUCH = '1;

    // result queue
    localparam int OQ_DEPTH    = 8;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

    // configuration port
    localparam int PADDR_W     = 5;
    localparam logic signed [COORD_W-1:0] GAIN_RST  = 16'sd16384;
    localparam logic [RANGE_W-1:0]        AGREE_RST = 12'd50;

    typedef enum logic [2:0] {
        REG_RAW_MODE    = 3'd0,
        REG_X_GAIN      = 3'd1,
        REG_X_OFFSET    = 3'd2,
        REG_Y_GAIN      = 3'd3,
        REG_Y_OFFSET    = 3'd4,
        REG_AGREE_RANGE = 3'd5
    } t_reg_idx;

    // group positions inside one scan
    localparam logic [1:0] PH_X1 = 2'd0;
    localparam logic [1:0] PH_Y1 = 2'd1;
    localparam logic [1:0] PH_X2 = 2'd2;
    localparam logic [1:0] PH_Y2 = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    // link between neighboring sort cells
    typedef struct packed {
        logic    gt;
        logic    valid;
        t_sample val;
    } t_link;

    // insert command broadcast to all cells
    typedef struct packed {
        logic    we;
        logic    clear;
        t_sample sample;
    } t_ins;

    // per-beat control token walking down the pipeline
    typedef struct packed {
        logic       vld;
        logic       ack;
        logic       rel;
        logic       grp;
        logic       res;
        logic       agreed;
        logic [1:0] phase;
    } t_tok;

    typedef struct packed {
        logic               pressed;
        logic               caught;
        logic               pair_agreed;
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
    } t_result;

endpackage

FILE: src/tsq_if.sv
interface tsq_in_if import tsq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                pen_down;
    logic [SMP_IN_W-1:0] sample;
    logic                ack_catch;

    modport source (output valid, output pen_down, output sample, output ack_catch,
                    input ready);
    modport sink   (input valid, input pen_down, input sample, input ack_catch,
                    output ready);
endinterface

interface tsq_out_if import tsq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               pressed;
    logic               caught;
    logic               pair_agreed;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;

    modport source (output valid, output pressed, output caught, output pair_agreed,
                    output cur_x, output cur_y, output first_x, output first_y,
                    input ready);
    modport sink   (input valid, input pressed, input caught, input pair_agreed,
                    input cur_x, input cur_y, input first_x, input first_y,
                    output ready);
endinterface

FILE: src/touch_sample_qualifier.sv
// Touch sample qualifier: takes one converter sample per beat, with no gaps
// needed between beats. Samples pass through a row of insertion-sort cells, so
// each group is sorted as it arrives; its trimmed mean is summed into r_sum
// and divided into r_mean, and the scan verdict, calibration multiply and flag
// update follow in token stages r_tok4 to r_tok6. A result beat is queued
// from r_tok6 for the beat that causes it (the fourth group's last sample, or
// a release tick). Input ready drops only when the 8-entry output queue plus
// the results still in the pipeline would fill it, that is when the consumer
// stalls. Registers sit at byte addresses 0, 4, .., 20 and must be written
// while no beat is in flight.
module touch_sample_qualifier import tsq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tsq_in_if.sink             i_sample_ch,
    tsq_out_if.source          o_result_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------- configuration ----------------
    logic                      r_raw_mode;
    logic signed [COORD_W-1:0] r_x_gain;
    logic signed [COORD_W-1:0] r_x_offset;
    logic signed [COORD_W-1:0] r_y_gain;
    logic signed [COORD_W-1:0] r_y_offset;
    logic [RANGE_W-1:0]        r_agree_range;
    logic                      cfg_we;
    t_reg_idx                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode    <= 1'b0;
            r_x_gain      <= GAIN_RST;
            r_x_offset    <= '0;
            r_y_gain      <= GAIN_RST;
            r_y_offset    <= '0;
            r_agree_range <= AGREE_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_RAW_MODE:    r_raw_mode    <= pwdata[0];
                REG_X_GAIN:      r_x_gain      <= pwdata[COORD_W-1:0];
                REG_X_OFFSET:    r_x_offset    <= pwdata[COORD_W-1:0];
                REG_Y_GAIN:      r_y_gain      <= pwdata[COORD_W-1:0];
                REG_Y_OFFSET:    r_y_offset    <= pwdata[COORD_W-1:0];
                REG_AGREE_RANGE: r_agree_range <= pwdata[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_RAW_MODE:    prdata = 32'(r_raw_mode);
            REG_X_GAIN:      prdata = 32'(unsigned'(r_x_gain));
            REG_X_OFFSET:    prdata = 32'(unsigned'(r_x_offset));
            REG_Y_GAIN:      prdata = 32'(unsigned'(r_y_gain));
            REG_Y_OFFSET:    prdata = 32'(unsigned'(r_y_offset));
            REG_AGREE_RANGE: prdata = 32'(r_agree_range);
            default:         prdata = '0;
        endcase
    end

    // ---------------- intake and sort cells ----------------
    logic                in_acc;
    logic                slot_last;
    logic [SLOT_W-1:0]   r_slot;
    logic [1:0]          r_phase;
    t_ins                ins;
    t_link               links [GROUP_SIZE+1];
    t_tok                n_tok1;
    t_tok                r_tok1;
    t_tok                r_tok2;
    t_tok                r_tok3;
    t_tok                n_tok4;
    t_tok                r_tok4;
    t_tok                r_tok5;
    t_tok                r_tok6;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W:0]   oq_used;

    assign oq_used = (OQ_CNT_W+1)'(oq_count)
                   + (OQ_CNT_W+1)'($countones({r_tok1.vld && r_tok1.res,
                                               r_tok2.vld && r_tok2.res,
                                               r_tok3.vld && r_tok3.res,
                                               r_tok4.vld && r_tok4.res,
                                               r_tok5.vld && r_tok5.res,
                                               r_tok6.vld && r_tok6.res}));
    assign i_sample_ch.ready = (oq_used < (OQ_CNT_W+1)'(OQ_DEPTH));
    assign in_acc            = i_sample_ch.valid && i_sample_ch.ready;
    assign slot_last         = (r_slot == SLOT_W'(GROUP_SIZE - 1));

    always_comb begin
        ins.we     = in_acc && i_sample_ch.pen_down;
        ins.clear  = (r_slot == '0);
        ins.sample = t_sample'(i_sample_ch.sample);

        n_tok1.vld    = in_acc;
        n_tok1.ack    = i_sample_ch.ack_catch;
        n_tok1.rel    = !i_sample_ch.pen_down;
        n_tok1.grp    = i_sample_ch.pen_down && slot_last;
        n_tok1.phase  = r_phase;
        n_tok1.res    = !i_sample_ch.pen_down || (slot_last && r_phase == PH_Y2);
        n_tok1.agreed = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_phase <= PH_X1;
        end else if (in_acc) begin
            if (!i_sample_ch.pen_down) begin
                r_slot  <= '0;
                r_phase <= PH_X1;
            end else if (slot_last) begin
                r_slot  <= '0;
                r_phase <= r_phase + 2'd1;
            end else begin
                r_slot  <= r_slot + 1'b1;
            end
        end
    end

    assign links[0] = '{gt: 1'b0, valid: 1'b1, val: '0};

    for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_cells
        tsq_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ins  (ins),
            .i_left (links[g]),
            .o_link (links[g+1])
        );
    end

    // ---------------- token pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= '0;
            r_tok2 <= '0;
            r_tok3 <= '0;
            r_tok4 <= '0;
            r_tok5 <= '0;
            r_tok6 <= '0;
        end else begin
            r_tok1 <= n_tok1;
            r_tok2 <= r_tok1;
            r_tok3 <= r_tok2;
            r_tok4 <= n_tok4;
            r_tok5 <= r_tok4;
            r_tok6 <= r_tok5;
        end
    end

    // stage 2: sum of the kept middle of the sorted group
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] r_sum;

    always_comb begin
        n_sum = '0;
        if (TRIM_ALL) begin
            n_sum = SUM_W'(links[GROUP_SIZE/2 + 1].val);
        end else begin
            for (int k = TRIM_COUNT; k < GROUP_SIZE - TRIM_COUNT; k++) begin
                n_sum = n_sum + SUM_W'(links[k+1].val);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // stage 3: divide by the kept count through a reciprocal
    logic [DIV_PROD_W-1:0] div_prod;
    t_sample               r_mean;

    assign div_prod = DIV_PROD_W'(r_sum) * DIV_PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        r_mean <= div_prod[DIV_SHIFT +: SAMPLE_BITS];
    end

    // stage 4: per-group store, agreement and pair averages
    t_sample                r_fpx;
    t_sample                r_fpy;
    t_sample                r_spx;
    logic                   agree_x;
    logic                   agree_y;
    logic [SAMPLE_BITS:0]   pair_x;
    logic [SAMPLE_BITS:0]   pair_y;
    t_sample                r_ax;
    t_sample                r_ay;

    function automatic t_sample abs_diff(input t_sample a, input t_sample b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign agree_x = CMP_W'(abs_diff(r_fpx, r_spx))  < CMP_W'(r_agree_range);
    assign agree_y = CMP_W'(abs_diff(r_fpy, r_mean)) < CMP_W'(r_agree_range);
    assign pair_x  = (SAMPLE_BITS+1)'(r_fpx) + (SAMPLE_BITS+1)'(r_spx);
    assign pair_y  = (SAMPLE_BITS+1)'(r_fpy) + (SAMPLE_BITS+1)'(r_mean);

    always_comb begin
        n_tok4        = r_tok3;
        n_tok4.agreed = r_tok3.grp && (r_tok3.phase == PH_Y2) && agree_x && agree_y;
    end

    always_ff @(posedge i_clk) begin
        if (r_tok3.vld && r_tok3.grp) begin
            unique case (r_tok3.phase)
                PH_X1:   r_fpx <= r_mean;
                PH_Y1:   r_fpy <= r_mean;
                PH_X2:   r_spx <= r_mean;
                PH_Y2: ;
                default: ;
            endcase
        end
        r_ax <= pair_x[SAMPLE_BITS:1];
        r_ay <= pair_y[SAMPLE_BITS:1];
    end

    // stages 5 and 6: calibration
    logic [COORD_W-1:0] map_x;
    logic [COORD_W-1:0] map_y;

    tsq_coord_map u_map_x (
        .i_clk     (i_clk),
        .i_value   (r_ax),
        .i_gain    (r_x_gain),
        .i_offset  (r_x_offset),
        .i_raw_mode(r_raw_mode),
        .o_coord   (map_x)
    );

    tsq_coord_map u_map_y (
        .i_clk     (i_clk),
        .i_value   (r_ay),
        .i_gain    (r_y_gain),
        .i_offset  (r_y_offset),
        .i_raw_mode(r_raw_mode),
        .o_coord   (map_y)
    );

    // ---------------- touch state and result ----------------
    logic               r_pressed;
    logic               r_caught;
    logic [COORD_W-1:0] r_cur_x;
    logic [COORD_W-1:0] r_cur_y;
    logic [COORD_W-1:0] r_first_x;
    logic [COORD_W-1:0] r_first_y;
    logic               n_pressed;
    logic               n_caught;
    logic [COORD_W-1:0] n_cur_x;
    logic [COORD_W-1:0] n_cur_y;
    logic [COORD_W-1:0] n_first_x;
    logic [COORD_W-1:0] n_first_y;
    logic               scan_done;
    logic               oq_push;
    logic               oq_pop;
    logic               oq_valid;
    t_result            oq_in;
    t_result            oq_out;

    assign scan_done = r_tok6.grp && (r_tok6.phase == PH_Y2);

    always_comb begin
        n_pressed = r_pressed;
        n_caught  = r_caught;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        if (r_tok6.vld) begin
            if (r_tok6.ack) begin
                n_caught = 1'b0;
            end
            if (scan_done) begin
                if (r_tok6.agreed) begin
                    n_cur_x = map_x;
                    n_cur_y = map_y;
                end
                // press edge: latch the position even if this scan disagreed
                if (!r_pressed) begin
                    n_pressed = 1'b1;
                    n_caught  = 1'b1;
                    n_first_x = n_cur_x;
                    n_first_y = n_cur_y;
                end
            end else if (r_tok6.rel) begin
                if (r_pressed) begin
                    n_pressed = 1'b0;
                end else begin
                    n_first_x = '0;
                    n_first_y = '0;
                    n_cur_x   = NO_TOUCH;
                    n_cur_y   = NO_TOUCH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_caught  <= 1'b0;
            r_cur_x   <= NO_TOUCH;
            r_cur_y   <= NO_TOUCH;
            r_first_x <= '0;
            r_first_y <= '0;
        end else begin
            r_pressed <= n_pressed;
            r_caught  <= n_caught;
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
        end
    end

    assign oq_push = r_tok6.vld && r_tok6.res;
    assign oq_pop  = oq_valid && o_result_ch.ready;
    assign oq_in   = '{pressed:     n_pressed,
                       caught:      n_caught,
                       pair_agreed: r_tok6.agreed,
                       cur_x:       n_cur_x,
                       cur_y:       n_cur_y,
                       first_x:     n_first_x,
                       first_y:     n_first_y};

    tsq_out_fifo u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (oq_push),
        .i_data (oq_in),
        .i_pop  (oq_pop),
        .o_valid(oq_valid),
        .o_data (oq_out),
        .o_count(oq_count)
    );

    assign o_result_ch.valid       = oq_valid;
    assign o_result_ch.pressed     = oq_out.pressed;
    assign o_result_ch.caught      = oq_out.caught;
    assign o_result_ch.pair_agreed = oq_out.pair_agreed;
    assign o_result_ch.cur_x       = oq_out.cur_x;
    assign o_result_ch.cur_y       = oq_out.cur_y;
    assign o_result_ch.first_x     = oq_out.first_x;
    assign o_result_ch.first_y     = oq_out.first_y;

    // a release beat drops any partial scan
    a_release_restarts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_sample_ch.pen_down) |=> (r_slot == '0 && r_phase == PH_X1))
        else $error("partial scan survived a release beat");

    // a completed scan with the pen up starts a press and raises caught
    a_press_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok6.vld && scan_done && !r_pressed) |=> (r_pressed && r_caught))
        else $error("press edge not recorded");

    // agreement can only be reported on the beat that closes a scan
    a_agree_only_on_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok6.vld && r_tok6.agreed) |-> (scan_done && r_tok6.res))
        else $error("agreement flagged outside a scan close");

    a_release_unpresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok6.vld && r_tok6.rel && r_pressed) |=> !r_pressed)
        else $error("release beat did not clear pressed");

endmodule

FILE: src/tsq_cell.sv
module tsq_cell import tsq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ins  i_ins,
    input  t_link i_left,
    output t_link o_link
);

    logic    r_valid;
    t_sample r_val;
    t_sample n_val;
    logic    eff_valid;
    logic    gt;

    // an empty cell counts as larger than anything
    assign eff_valid = r_valid && !i_ins.clear;
    assign gt        = !eff_valid || (r_val > i_ins.sample);
    assign n_val     = i_left.gt ? i_left.val : i_ins.sample;

    assign o_link = '{gt: gt, valid: eff_valid, val: r_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ins.we) begin
            r_valid <= i_left.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins.we && gt) begin
            r_val <= n_val;
        end
    end

endmodule

FILE: src/tsq_coord_map.sv
module tsq_coord_map import tsq_pkg::*; (
    input  logic                      i_clk,
    input  t_sample                   i_value,
    input  logic signed [COORD_W-1:0] i_gain,
    input  logic signed [COORD_W-1:0] i_offset,
    input  logic                      i_raw_mode,
    output logic [COORD_W-1:0]        o_coord
);

    logic signed [PROD_W-1:0] gain_x;
    logic signed [PROD_W-1:0] value_x;
    logic signed [PROD_W-1:0] r_prod;
    t_sample                  r_raw;
    logic signed [MAP_W-1:0]  off_x;
    logic signed [MAP_W-1:0]  sum;
    logic signed [MAP_W-1:0]  quot;
    logic [COORD_W-1:0]       sat;
    logic [COORD_W-1:0]       r_coord;

    assign gain_x  = PROD_W'(i_gain);
    assign value_x = $signed(PROD_W'(i_value));

    always_ff @(posedge i_clk) begin
        r_prod <= gain_x * value_x;
        r_raw  <= i_value;
    end

    always_comb begin
        off_x = MAP_W'(i_offset) <<< GAIN_FRAC;
        sum   = MAP_W'(r_prod) + off_x;
        quot  = sum >>> GAIN_FRAC;
        if (sum[MAP_W-1]) begin
            sat = '0;
        end else if (|quot[MAP_W-1:COORD_W]) begin
            sat = '1;
        end else begin
            sat = quot[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord <= i_raw_mode ? COORD_W'(r_raw) : sat;
    end

    assign o_coord = r_coord;

endmodule

FILE: src/tsq_out_fifo.sv
module tsq_out_fifo import tsq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_result             i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output t_result             o_data,
    output logic [OQ_CNT_W-1:0] o_count
);

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr;
    logic [OQ_PTR_W-1:0] r_rd;
    logic [OQ_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    // credit check upstream must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != OQ_CNT_W'(OQ_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("result queue underflow");

endmodule

FILE: sim/touch_sample_qualifier_tb.sv
module touch_sample_qualifier_tb import tsq_pkg::*; ;

    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 120;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 6;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic                pen;
        logic [SMP_IN_W-1:0] smp;
        logic                ack;
        logic                typed;
        t_result             want;
    } t_beat;

    typedef struct packed {
        logic        raw;
        logic [15:0] xg;
        logic [15:0] xo;
        logic [15:0] yg;
        logic [15:0] yo;
        logic [11:0] agree;
    } t_setting;

    localparam t_result NONE_RES = '0;
    localparam t_result IDLE_RES = '{1'b0, 1'b0, 1'b0, NO_TOUCH, NO_TOUCH, 16'd0, 16'd0};
    localparam t_result PRESS_RES = '{1'b1, 1'b1, 1'b1, 16'd1000, 16'd2000, 16'd1000, 16'd2000};
    localparam t_result LIFT_RES = '{1'b0, 1'b0, 1'b0, 16'd1000, 16'd2000, 16'd1000, 16'd2000};

    // pen-up ticks on both branches, one full scan with trimmed extremes, a torn scan
    localparam t_beat DIRECTED_ROWS [24] = '{
        '{1'b0, 12'd0,    1'b1, 1'b1, IDLE_RES},
        '{1'b1, 12'd0,    1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd4095, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd1000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd1000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd1000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd4095, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd0,    1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd1001, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd999,  1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd1000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd4095, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd0,    1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b1, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b0, NONE_RES},
        '{1'b1, 12'd2000, 1'b0, 1'b1, PRESS_RES},
        '{1'b1, 12'd4095, 1'b1, 1'b0, NONE_RES},
        '{1'b0, 12'd4095, 1'b0, 1'b1, LIFT_RES},
        '{1'b0, 12'd0,    1'b0, 1'b1, IDLE_RES}
    };

    localparam t_setting FIXED_SETTINGS [4] = '{
        '{1'b1, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 12'd4095},
        '{1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 12'd1},
        '{1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 12'd0},
        '{1'b0, 16'h0000, 16'hFFFF, 16'h0001, 16'h0064, 12'd2048}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tsq_in_if  in_ch ();
    tsq_out_if out_ch ();

    touch_sample_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (in_ch),
        .o_result_ch (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic               cfg_raw = 1'b0;
    logic signed [15:0] cfg_gain [2] = '{16'sd16384, 16'sd16384};
    logic signed [15:0] cfg_off [2]  = '{16'sd0, 16'sd0};
    logic [11:0]        cfg_agree    = 12'd50;

    int      scan_pos = 0;
    t_sample grp_store [GROUP_SIZE] = '{default: '0};
    t_sample x_pass1 = '0, y_pass1 = '0, x_pass2 = '0;
    logic [COORD_W-1:0] pos_now [2]   = '{NO_TOUCH, NO_TOUCH};
    logic [COORD_W-1:0] pos_press [2] = '{16'd0, 16'd0};
    logic pen_held = 1'b0;
    logic caught   = 1'b0;

    t_result pending_results [$];
    int      mismatch_count = 0;

    function automatic t_sample trimmed_group_mean();
        t_sample     srt [GROUP_SIZE];
        t_sample     v;
        int          j;
        int unsigned total;
        srt = grp_store;
        for (int i = 1; i < GROUP_SIZE; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        if (2 * TRIM_COUNT >= GROUP_SIZE)
            return srt[GROUP_SIZE/2];
        total = 0;
        for (int i = TRIM_COUNT; i < GROUP_SIZE - TRIM_COUNT; i++)
            total += srt[i];
        return t_sample'(total / (GROUP_SIZE - 2 * TRIM_COUNT));
    endfunction

    function automatic bit close_enough(input t_sample a, input t_sample b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0)
            d = -d;
        return d < int'(cfg_agree);
    endfunction

    function automatic logic [COORD_W-1:0] map_axis(input int val, input logic signed [15:0] gain,
                                                    input logic signed [15:0] off);
        longint acc;
        acc = longint'(gain) * longint'(val) + longint'(off) * (longint'(1) << GAIN_FRAC);
        if (acc < 0)
            return '0;
        acc = acc >>> GAIN_FRAC;
        if (acc > 65535)
            return '1;
        return COORD_W'(acc);
    endfunction

    // one accepted beat; returns 1 when it yields a result beat
    function automatic bit scan_step(input logic pen, input t_sample smp, input logic ack,
                                     output t_result res);
        t_sample m;
        bit      agreed;
        int      ax, ay;
        res    = '0;
        agreed = 1'b0;
        if (ack)
            caught = 1'b0;
        if (pen) begin
            if (scan_pos >= 4 * GROUP_SIZE)
                scan_pos = 0;
            grp_store[scan_pos % GROUP_SIZE] = smp;
            scan_pos++;
            if (scan_pos % GROUP_SIZE != 0)
                return 1'b0;
            m = trimmed_group_mean();
            case (2'(scan_pos / GROUP_SIZE - 1))
                PH_X1: begin
                    x_pass1 = m;
                    return 1'b0;
                end
                PH_Y1: begin
                    y_pass1 = m;
                    return 1'b0;
                end
                PH_X2: begin
                    x_pass2 = m;
                    return 1'b0;
                end
                default: ;
            endcase
            scan_pos = 0;
            if (close_enough(x_pass1, x_pass2) && close_enough(y_pass1, m)) begin
                ax = (int'(x_pass1) + int'(x_pass2)) / 2;
                ay = (int'(y_pass1) + int'(m)) / 2;
                if (cfg_raw) begin
                    pos_now[0] = COORD_W'(ax);
                    pos_now[1] = COORD_W'(ay);
                end else begin
                    pos_now[0] = map_axis(ax, cfg_gain[0], cfg_off[0]);
                    pos_now[1] = map_axis(ay, cfg_gain[1], cfg_off[1]);
                end
                agreed = 1'b1;
            end
            if (!pen_held) begin
                pen_held  = 1'b1;
                caught    = 1'b1;
                pos_press = pos_now;
            end
        end else begin
            scan_pos = 0;
            if (pen_held) begin
                pen_held = 1'b0;
            end else begin
                pos_press = '{16'd0, 16'd0};
                pos_now   = '{NO_TOUCH, NO_TOUCH};
            end
        end
        res = '{pen_held, caught, agreed, pos_now[0], pos_now[1], pos_press[0], pos_press[1]};
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        if (mismatch_count < 100)
            $display("MISMATCH %s: want %0d got %0d at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    // ---------------- monitors ----------------
    t_beat offer = '0;

    always @(posedge i_clk) begin : beat_intake
        t_result res;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (scan_step(in_ch.pen_down, in_ch.sample[SAMPLE_BITS-1:0], in_ch.ack_catch, res))
                pending_results.push_back(offer.typed ? offer.want : res);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result beat with none pending", 64'd0, 64'd1);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.pressed !== want.pressed)
                    flag_mismatch("pressed", 64'(want.pressed), 64'(out_ch.pressed));
                if (out_ch.caught !== want.caught)
                    flag_mismatch("caught", 64'(want.caught), 64'(out_ch.caught));
                if (out_ch.pair_agreed !== want.pair_agreed)
                    flag_mismatch("pair_agreed", 64'(want.pair_agreed),
                                  64'(out_ch.pair_agreed));
                if (out_ch.cur_x !== want.cur_x)
                    flag_mismatch("cur_x", 64'(want.cur_x), 64'(out_ch.cur_x));
                if (out_ch.cur_y !== want.cur_y)
                    flag_mismatch("cur_y", 64'(want.cur_y), 64'(out_ch.cur_y));
                if (out_ch.first_x !== want.first_x)
                    flag_mismatch("first_x", 64'(want.first_x), 64'(out_ch.first_x));
                if (out_ch.first_y !== want.first_y)
                    flag_mismatch("first_y", 64'(want.first_y), 64'(out_ch.first_y));
            end
        end
    end

    // ---------------- result consumer ----------------
    logic rx_ready   = 1'b0;
    int   hold_start = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   rx_mode    = 0;
    int   rx_window  = 0;

    assign out_ch.ready = rx_ready;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready  <= 1'b0;
            hold_left <= 0;
            rx_window <= 0;
        end else if (hold_seen != hold_start) begin
            hold_seen <= hold_start;
            hold_left <= LONG_HOLD;
            rx_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            if (rx_window == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                rx_window <= $urandom_range(16, 96);
            end else begin
                rx_window <= rx_window - 1;
            end
            case (rx_mode)
                0: rx_ready <= 1'b1;
                1: rx_ready <= ($urandom_range(0, 3) != 0);
                2: rx_ready <= ($urandom_range(0, 3) == 0);
                default: rx_ready <= rx_window[2];
            endcase
        end
    end

    // ---------------- sample producer ----------------
    int n_sent     = 0;
    int burst_left = 0;
    bit steady     = 1'b0;

    task automatic send_beat(input t_beat b);
        in_ch.valid     <= 1'b1;
        in_ch.pen_down  <= b.pen;
        in_ch.sample    <= b.smp;
        in_ch.ack_catch <= b.ack;
        offer           <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic push_beat(input t_beat b);
        if (burst_left == 0) begin
            if (!steady && $urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_beat(b);
    endtask

    function automatic t_beat beat_of(input logic pen, input logic [SMP_IN_W-1:0] smp);
        t_beat b;
        b       = '0;
        b.pen   = pen;
        b.smp   = smp;
        b.ack   = ($urandom_range(0, 5) == 0);
        return b;
    endfunction

    function automatic logic [SMP_IN_W-1:0] jitter(input int centre, input int spread);
        int v;
        if (spread < 0 || $urandom_range(0, 15) == 0)
            return SMP_IN_W'($urandom);
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SMP_IN_W'(v);
    endfunction

    task automatic send_group(input int centre, input int spread);
        for (int k = 0; k < GROUP_SIZE; k++)
            push_beat(beat_of(1'b1, jitter(centre, spread)));
    endtask

    // X, Y, X, Y groups; the second pass drifts by zero, around the agree range, by up to 100, or anywhere
    task automatic send_scan();
        int cx, cy, sp, dx, dy;
        cx = $urandom_range(0, SAMPLE_MAX);
        cy = $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 3))
            0: sp = 0;
            1: sp = $urandom_range(0, 15);
            2: sp = $urandom_range(0, 300);
            default: sp = -1;
        endcase
        case ($urandom_range(0, 3))
            0: dx = 0;
            1: dx = int'(cfg_agree) + int'($urandom_range(0, 3)) - 2;
            2: dx = $urandom_range(0, 100);
            default: dx = $urandom_range(0, SAMPLE_MAX);
        endcase
        case ($urandom_range(0, 3))
            0: dy = 0;
            1: dy = int'(cfg_agree) + int'($urandom_range(0, 3)) - 2;
            2: dy = $urandom_range(0, 100);
            default: dy = $urandom_range(0, SAMPLE_MAX);
        endcase
        if ($urandom_range(0, 1))
            dx = -dx;
        if ($urandom_range(0, 1))
            dy = -dy;
        send_group(cx, sp);
        send_group(cy, sp);
        send_group(cx + dx, sp);
        send_group(cy + dy, sp);
    endtask

    task automatic run_phase(input int target);
        int stop_at, r;
        stop_at = n_sent + target;
        while (n_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_scan();
                if ($urandom_range(0, 2) == 0)
                    push_beat(beat_of(1'b0, SMP_IN_W'($urandom)));
            end else if (r < 85) begin
                // scan torn off by a release
                repeat ($urandom_range(1, 4 * GROUP_SIZE - 1))
                    push_beat(beat_of(1'b1, SMP_IN_W'($urandom)));
                push_beat(beat_of(1'b0, SMP_IN_W'($urandom)));
            end else if (r < 93) begin
                repeat ($urandom_range(1, 3))
                    push_beat(beat_of(1'b0, SMP_IN_W'($urandom)));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_beat(beat_of(1'($urandom_range(0, 1)), SMP_IN_W'($urandom)));
            end
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // back-to-back writes go straight from access to the next setup
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RAW_MODE:    cfg_raw     = data[0];
            REG_X_GAIN:      cfg_gain[0] = data[15:0];
            REG_X_OFFSET:    cfg_off[0]  = data[15:0];
            REG_Y_GAIN:      cfg_gain[1] = data[15:0];
            REG_Y_OFFSET:    cfg_off[1]  = data[15:0];
            REG_AGREE_RANGE: cfg_agree   = data[11:0];
            default: ;
        endcase
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------- main sequence ----------------
    initial begin
        t_setting s;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.pen_down  <= 1'b0;
        in_ch.sample    <= '0;
        in_ch.ack_catch <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            push_beat(DIRECTED_ROWS[i]);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) begin
                s = FIXED_SETTINGS[p];
            end else begin
                s.raw   = 1'($urandom_range(0, 1));
                s.xg    = 16'($urandom);
                s.xo    = 16'($urandom);
                s.yg    = 16'($urandom);
                s.yo    = 16'($urandom);
                s.agree = $urandom_range(0, 1) ? 12'($urandom_range(1, 200)) : 12'($urandom);
            end
            apb_write(REG_RAW_MODE,    {31'd0, s.raw});
            apb_write(REG_X_GAIN,      {16'd0, s.xg});
            apb_write(REG_X_OFFSET,    {16'd0, s.xo});
            apb_write(REG_Y_GAIN,      {16'd0, s.yg});
            apb_write(REG_Y_OFFSET,    {16'd0, s.yo});
            apb_write(REG_AGREE_RANGE, {20'd0, s.agree});
            apb_idle();
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            if (p == 1) begin
                // consumer blocks while every release beat yields a result
                hold_start <= hold_start + 1;
                repeat (40)
                    send_beat(beat_of(1'b0, SMP_IN_W'($urandom)));
            end
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (pending_results.size() != 0)
            flag_mismatch("results never seen", 64'd0, 64'(pending_results.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
